/* src/sip_pkg.sv */
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants of the inbound SMS frame parser
// Frame type codes, field checks, result kinds and the result record.
// ----------------------------------------------------------------------------
package sip_pkg;

  // Frame type and field codes
  localparam logic [7:0] TYPE_DELIVER    = 8'h04;
  localparam logic [7:0] TYPE_SUBMIT_ACK = 8'h07;
  localparam logic [7:0] ADDRESS_TYPE    = 8'hC9;
  localparam logic [7:0] NIBBLE_MASK     = 8'h0F;

  // Result kinds
  localparam logic [2:0] KIND_MSGREF = 3'd0;
  localparam logic [2:0] KIND_RCPT   = 3'd1;
  localparam logic [2:0] KIND_SENDER = 3'd2;
  localparam logic [2:0] KIND_TIME   = 3'd3;
  localparam logic [2:0] KIND_SEPTET = 3'd4;
  localparam logic [2:0] KIND_ACCEPT = 3'd5;
  localparam logic [2:0] KIND_REJECT = 3'd6;
  localparam logic [2:0] KIND_DLEN   = 3'd7;

  // Most results per octet and result queue size
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Parser phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE = 10'b00_0000_0001,
    PH_REF  = 10'b00_0000_0010,
    PH_LEN  = 10'b00_0000_0100,
    PH_TOA  = 10'b00_0000_1000,
    PH_ADDR = 10'b00_0001_0000,
    PH_PID  = 10'b00_0010_0000,
    PH_DCS  = 10'b00_0100_0000,
    PH_TS   = 10'b00_1000_0000,
    PH_DLEN = 10'b01_0000_0000,
    PH_DATA = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } result_t;

endpackage : sip_pkg

/* src/sms_inbound_pdu_parser.sv */
// ----------------------------------------------------------------------------
// sms_inbound_pdu_parser: inbound SMS frame parser
// Parses deliver and submit-ack frames one octet per request and emits
// digits, septets, length, reference and a final accept or reject.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, octet_i,          | sink
//          | frame_start_i                             |
//  out     | out_valid_o, out_stall_i, kind_o,         | source
//          | value_o, last_o                           |
//
// An octet is parsed in the cycle it is taken; its zero to three results are
// written into a four-entry result queue and leave one per cycle while the
// output is not stalled. The input stalls while fewer than three queue entries
// are free, so a new octet is taken only while at most one result still waits.
// A result is registered in the queue and reaches the output after the ones
// ahead of it. Reset returns the parser to idle and empties the queue.
module sms_inbound_pdu_parser #(
  parameter int unsigned MAX_ADDRESS_DIGITS = 20,
  parameter int unsigned TIMESTAMP_DIGITS   = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] octet_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic       last_o
);
  import sip_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Parser state
  phase_e     phase_q, phase_d;
  logic       is_deliver_q, is_deliver_d;
  logic [4:0] digits_left_q, digits_left_d;
  logic [7:0] septets_left_q, septets_left_d;
  logic [6:0] carry_bits_q, carry_bits_d;
  logic [2:0] bit_borrow_q, bit_borrow_d;

  // Result queue
  result_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  result_t    res [MAX_RESULTS];
  logic [1:0] res_n;
  logic       in_acc;
  logic       out_pop;

  assign in_stall_o  = count_q > CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_pop     = out_valid_o & ~out_stall_i;
  assign kind_o      = queue_q[rd_ptr_q].kind;
  assign value_o     = queue_q[rd_ptr_q].value;
  assign last_o      = queue_q[rd_ptr_q].last;

  // Parse one octet: next state and the results it causes
  always_comb begin
    logic [1:0]  n;
    logic [2:0]  dkind;
    logic [4:0]  dl1;
    logic [2:0]  b;
    logic [14:0] shifted;
    logic [6:0]  septet;
    logic [6:0]  carry;
    logic [7:0]  sl;

    phase_d        = phase_q;
    is_deliver_d   = is_deliver_q;
    digits_left_d  = digits_left_q;
    septets_left_d = septets_left_q;
    carry_bits_d   = carry_bits_q;
    bit_borrow_d   = bit_borrow_q;
    n              = '0;
    dkind          = is_deliver_q ? KIND_SENDER : KIND_RCPT;
    dl1            = '0;
    b              = (bit_borrow_q > 3'd6) ? 3'd0 : bit_borrow_q;
    shifted        = 15'(octet_i) << b;
    septet         = shifted[6:0] | carry_bits_q;
    carry          = 7'(octet_i >> (3'd7 - b));
    sl             = septets_left_q - 8'd1;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    if (frame_start_i) begin
      // Type octet: restart the frame
      if (octet_i == TYPE_DELIVER) begin
        is_deliver_d = 1'b1;
        phase_d      = PH_LEN;
      end else if (octet_i == TYPE_SUBMIT_ACK) begin
        is_deliver_d = 1'b0;
        phase_d      = PH_REF;
      end else begin
        is_deliver_d = 1'b0;
        res[n]       = '{KIND_REJECT, 8'd0, 1'b0};
        n            = n + 2'd1;
        phase_d      = PH_IDLE;
      end
    end else begin
      case (phase_q)
        PH_REF: begin
          res[n]  = '{KIND_MSGREF, octet_i, 1'b0};
          n       = n + 2'd1;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (octet_i == 8'd0 || octet_i > 8'(MAX_ADDRESS_DIGITS)) begin
            res[n]  = '{KIND_REJECT, 8'd0, 1'b0};
            n       = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            digits_left_d = octet_i[4:0];
            phase_d       = PH_TOA;
          end
        end
        PH_TOA: begin
          if (octet_i != ADDRESS_TYPE) begin
            res[n]  = '{KIND_REJECT, 8'd0, 1'b0};
            n       = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR, PH_TS: begin
          // Emit the high nibble, then the low one while digits remain
          if (phase_q == PH_TS) begin
            dkind = KIND_TIME;
          end
          res[n] = '{dkind, 8'(octet_i >> 4) & NIBBLE_MASK, 1'b0};
          n      = n + 2'd1;
          dl1    = (digits_left_q != 5'd0) ? digits_left_q - 5'd1 : 5'd0;
          digits_left_d = dl1;
          if (dl1 != 5'd0) begin
            res[n]        = '{dkind, octet_i & NIBBLE_MASK, 1'b0};
            n             = n + 2'd1;
            digits_left_d = dl1 - 5'd1;
          end
          if (digits_left_d == 5'd0) begin
            if (phase_q == PH_TS) begin
              phase_d = PH_DLEN;
            end else if (is_deliver_q) begin
              phase_d = PH_PID;
            end else begin
              res[n]  = '{KIND_ACCEPT, 8'd0, 1'b0};
              n       = n + 2'd1;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_PID: begin
          if (octet_i != 8'd0) begin
            res[n]  = '{KIND_REJECT, 8'd0, 1'b0};
            n       = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_DCS;
          end
        end
        PH_DCS: begin
          if (octet_i != 8'd0) begin
            res[n]  = '{KIND_REJECT, 8'd0, 1'b0};
            n       = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            digits_left_d = 5'(TIMESTAMP_DIGITS);
            phase_d       = PH_TS;
          end
        end
        PH_DLEN: begin
          res[n]         = '{KIND_DLEN, octet_i, 1'b0};
          n              = n + 2'd1;
          septets_left_d = octet_i;
          carry_bits_d   = '0;
          bit_borrow_d   = '0;
          if (octet_i == 8'd0) begin
            res[n]  = '{KIND_ACCEPT, 8'd0, 1'b0};
            n       = n + 2'd1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          // Unpack one septet; the seventh octet of a group also frees an eighth
          res[n]         = '{KIND_SEPTET, {1'b0, septet}, 1'b0};
          n              = n + 2'd1;
          septets_left_d = sl;
          carry_bits_d   = carry;
          bit_borrow_d   = b + 3'd1;
          if (b == 3'd6 && sl != 8'd0) begin
            res[n]         = '{KIND_SEPTET, {1'b0, carry}, 1'b0};
            n              = n + 2'd1;
            septets_left_d = sl - 8'd1;
            carry_bits_d   = '0;
            bit_borrow_d   = '0;
          end
          if (septets_left_d == 8'd0) begin
            carry_bits_d = '0;
            bit_borrow_d = '0;
            res[n]       = '{KIND_ACCEPT, 8'd0, 1'b0};
            n            = n + 2'd1;
            phase_d      = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // Mark the final result of this octet
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) == n - 2'd1 && n != 2'd0) begin
        res[i].last = 1'b1;
      end
    end
    res_n = n;
  end

  assign count_d = count_q + (in_acc ? CNT_W'(res_n) : CNT_W'(0))
                 - (out_pop ? CNT_W'(1) : CNT_W'(0));

  // Advance parser state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      is_deliver_q   <= 1'b0;
      digits_left_q  <= '0;
      septets_left_q <= '0;
      carry_bits_q   <= '0;
      bit_borrow_q   <= '0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      is_deliver_q   <= is_deliver_d;
      digits_left_q  <= digits_left_d;
      septets_left_q <= septets_left_d;
      carry_bits_q   <= carry_bits_d;
      bit_borrow_q   <= bit_borrow_d;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(res_n);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  // Write the results of an accepted request into the queue
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < res_n) begin
          queue_q[wr_ptr_q + QPTR_W'(i)] <= res[i];
        end
      end
    end
  end

endmodule : sms_inbound_pdu_parser

/* dv/sms_inbound_pdu_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_inbound_pdu_parser_tb: self-checking bench for the inbound SMS parser
// Drives short directed frames, then random deliver, submit-ack and noise
// traffic with random gaps and output stalls. A scoreboard class tracks the
// parser state, predicts every result and checks the output stream in order.
// ----------------------------------------------------------------------------
module sms_inbound_pdu_parser_tb;
  import sip_pkg::*;

  localparam int unsigned MAX_ADDR_DIGITS = 20;
  localparam int unsigned TS_DIGITS       = 14;
  localparam int          ITEM_TARGET     = 430;
  localparam int          HOLD_AFTER      = 120;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_CYCLES    = 20;

  typedef enum int {
    FAULT_NONE,
    FAULT_LEN,
    FAULT_TOA,
    FAULT_PID,
    FAULT_DCS,
    FAULT_CUT
  } frame_fault_e;

  // Frame state tracker, result predictor and in-order result checker
  class frame_result_board;
    phase_e     phase;
    logic       is_deliver;
    logic [4:0] digits_left;
    logic [7:0] septets_left;
    logic [6:0] carry_bits;
    logic [2:0] bit_borrow;
    result_t    pending_results[$];
    result_t    step_results[$];
    int         mismatch_count;

    function new();
      phase          = PH_IDLE;
      is_deliver     = 1'b0;
      digits_left    = '0;
      septets_left   = '0;
      carry_bits     = '0;
      bit_borrow     = '0;
      mismatch_count = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
    endtask

    function void add_result(logic [2:0] kind, logic [7:0] value);
      result_t r;
      if (step_results.size() >= MAX_RESULTS) return;
      r.kind  = kind;
      r.value = value;
      r.last  = 1'b0;
      step_results.push_back(r);
    endfunction

    function void close_frame(logic ok);
      add_result(ok ? KIND_ACCEPT : KIND_REJECT, 8'h00);
      phase = PH_IDLE;
    endfunction

    // High nibble first; drop the low nibble when the count runs out
    function void take_digits(logic [2:0] kind, logic [7:0] oct);
      add_result(kind, {4'h0, oct[7:4]});
      if (digits_left > 0) digits_left--;
      if (digits_left > 0) begin
        add_result(kind, oct & NIBBLE_MASK);
        digits_left--;
      end
    endfunction

    // Advance the parser by one accepted request and queue its results
    function void parse_octet(logic [7:0] oct, logic st);
      int unsigned shift;
      logic [7:0]  low_part;
      step_results.delete();
      if (st) begin
        if (oct == TYPE_DELIVER) begin
          is_deliver = 1'b1;
          phase      = PH_LEN;
        end else if (oct == TYPE_SUBMIT_ACK) begin
          is_deliver = 1'b0;
          phase      = PH_REF;
        end else begin
          is_deliver = 1'b0;
          close_frame(1'b0);
        end
      end else begin
        case (phase)
          PH_REF: begin
            add_result(KIND_MSGREF, oct);
            phase = PH_LEN;
          end
          PH_LEN: begin
            if (oct == 8'h00 || oct > MAX_ADDR_DIGITS) begin
              close_frame(1'b0);
            end else begin
              digits_left = oct[4:0];
              phase       = PH_TOA;
            end
          end
          PH_TOA: begin
            if (oct != ADDRESS_TYPE) close_frame(1'b0);
            else phase = PH_ADDR;
          end
          PH_ADDR: begin
            take_digits(is_deliver ? KIND_SENDER : KIND_RCPT, oct);
            if (digits_left == 0) begin
              if (is_deliver) phase = PH_PID;
              else close_frame(1'b1);
            end
          end
          PH_PID: begin
            if (oct != 8'h00) close_frame(1'b0);
            else phase = PH_DCS;
          end
          PH_DCS: begin
            if (oct != 8'h00) begin
              close_frame(1'b0);
            end else begin
              digits_left = 5'(TS_DIGITS);
              phase       = PH_TS;
            end
          end
          PH_TS: begin
            take_digits(KIND_TIME, oct);
            if (digits_left == 0) phase = PH_DLEN;
          end
          PH_DLEN: begin
            add_result(KIND_DLEN, oct);
            septets_left = oct;
            carry_bits   = '0;
            bit_borrow   = '0;
            if (oct == 8'h00) close_frame(1'b1);
            else phase = PH_DATA;
          end
          PH_DATA: begin
            // Merge fresh low bits with the carry of the previous octet
            shift    = (bit_borrow > 6) ? 0 : bit_borrow;
            low_part = (oct & (8'h7F >> shift)) << shift;
            add_result(KIND_SEPTET, {1'b0, low_part[6:0] | carry_bits});
            septets_left--;
            carry_bits = 7'((oct >> (7 - shift)) & 8'h7F);
            shift++;
            // Seventh octet leaves a whole septet in the carry
            if (shift == 7 && septets_left > 0) begin
              add_result(KIND_SEPTET, {1'b0, carry_bits});
              septets_left--;
              carry_bits = '0;
              shift      = 0;
            end
            bit_borrow = 3'(shift);
            if (septets_left == 0) begin
              carry_bits = '0;
              bit_borrow = '0;
              close_frame(1'b1);
            end
          end
          default: phase = PH_IDLE;
        endcase
      end
      if (step_results.size() > 0) step_results[$].last = 1'b1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    // Compare one accepted result against the oldest prediction
    task match_result(logic [2:0] kind, logic [7:0] value, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d value=0x%02h last=%0b",
                                kind, value, last));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (value !== want.value)
        flag_mismatch($sformatf("value 0x%02h, want 0x%02h (kind %0d)",
                                value, want.value, want.kind));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0b, want %0b (kind %0d)", last, want.last, want.kind));
    endtask
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] octet_i       = 8'h00;
  logic       frame_start_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] value_o;
  logic       last_o;

  frame_result_board frame_board = new();
  int                octets_parsed = 0;
  bit                sender_burst  = 1'b0;

  sms_inbound_pdu_parser #(
    .MAX_ADDRESS_DIGITS(MAX_ADDR_DIGITS),
    .TIMESTAMP_DIGITS  (TS_DIGITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .octet_i      (octet_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_octet(input logic [7:0] oct, input logic st);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    octet_i       <= oct;
    frame_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    if (st || frame_board.phase != PH_IDLE) octets_parsed++;
    frame_board.parse_octet(oct, st);
  endtask

  // Send a deliver frame, optionally broken at one field
  task automatic send_deliver(input frame_fault_e fault, input int text_len);
    int addr_len;
    int cut_at;
    int sent;
    addr_len = ($urandom_range(0, 4) == 0) ? MAX_ADDR_DIGITS : $urandom_range(1, 6);
    cut_at   = (fault == FAULT_CUT) ? $urandom_range(0, 3) : 1 << 20;
    sent     = 0;
    send_octet(TYPE_DELIVER, 1'b1);
    if (fault == FAULT_LEN) begin
      send_octet($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(MAX_ADDR_DIGITS + 1, 255)),
                 1'b0);
      return;
    end
    send_octet(8'(addr_len), 1'b0);
    send_octet((fault == FAULT_TOA) ? ADDRESS_TYPE ^ 8'($urandom_range(1, 255)) : ADDRESS_TYPE,
               1'b0);
    while (frame_board.phase == PH_ADDR) send_octet(8'($urandom()), 1'b0);
    send_octet((fault == FAULT_PID) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
    send_octet((fault == FAULT_DCS) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
    while (frame_board.phase == PH_TS) send_octet(8'($urandom()), 1'b0);
    if (frame_board.phase != PH_DLEN) return;
    send_octet(8'(text_len), 1'b0);
    // Text runs until the parser closes the frame, or is cut short
    while (frame_board.phase == PH_DATA && sent < cut_at) begin
      send_octet(8'($urandom()), 1'b0);
      sent++;
    end
  endtask

  // Result side: random stalls, burst stretches and one long hold-off
  initial begin : result_sink
    int stall_cycles;
    int taken;
    bit rx_burst;
    taken    = 0;
    rx_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      if (taken == HOLD_AFTER) stall_cycles = HOLD_CYCLES;
      else stall_cycles = rx_burst ? 0 : $urandom_range(0, 6);
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      frame_board.match_result(kind_o, value_o, last_o);
      taken++;
    end
  end

  // Main stimulus
  initial begin : stimulus
    frame_fault_e fault;
    int           frame_no;
    int           pick;
    int           text_len;
    int           addr_len;
    frame_no = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray byte outside a frame, then an unknown type
    send_octet(8'h00, 1'b0);
    send_octet(8'hFF, 1'b1);
    // Submit-ack with odd digit count and nibbles above nine
    send_octet(TYPE_SUBMIT_ACK, 1'b1); send_octet(8'hFF, 1'b0);
    send_octet(8'h01, 1'b0); send_octet(ADDRESS_TYPE, 1'b0); send_octet(8'hFA, 1'b0);
    // Address length zero and one above the limit
    send_octet(TYPE_DELIVER, 1'b1); send_octet(8'h00, 1'b0);
    send_octet(TYPE_SUBMIT_ACK, 1'b1); send_octet(8'h00, 1'b0);
    send_octet(8'(MAX_ADDR_DIGITS + 1), 1'b0);
    // Wrong address type
    send_octet(TYPE_DELIVER, 1'b1); send_octet(8'h02, 1'b0); send_octet(8'hC8, 1'b0);
    // Restart in the middle of the sender address
    send_octet(TYPE_DELIVER, 1'b1); send_octet(8'(MAX_ADDR_DIGITS), 1'b0);
    send_octet(ADDRESS_TYPE, 1'b0); send_octet(8'h12, 1'b0);
    send_octet(TYPE_SUBMIT_ACK, 1'b1); send_octet(8'h5A, 1'b0);
    send_octet(8'h02, 1'b0); send_octet(ADDRESS_TYPE, 1'b0); send_octet(8'h34, 1'b0);

    // Random traffic; the first frames pin the deliver corner cases
    while (octets_parsed < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) sender_burst = !sender_burst;
      fault    = ($urandom_range(0, 4) == 0) ? frame_fault_e'($urandom_range(1, 5)) : FAULT_NONE;
      text_len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 24);
      case (frame_no)
        0: send_deliver(FAULT_NONE, 0);
        1: send_deliver(FAULT_NONE, 8);
        2: send_deliver(FAULT_PID, 5);
        3: send_deliver(FAULT_DCS, 5);
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 12) begin
            send_deliver(fault, text_len);
          end else if (pick < 17) begin
            // Submit-ack frame, broken length or type on a fault
            addr_len = ($urandom_range(0, 4) == 0) ? MAX_ADDR_DIGITS : $urandom_range(1, 6);
            send_octet(TYPE_SUBMIT_ACK, 1'b1);
            send_octet(8'($urandom()), 1'b0);
            if (fault == FAULT_LEN) begin
              send_octet($urandom_range(0, 1) ? 8'h00 :
                         8'($urandom_range(MAX_ADDR_DIGITS + 1, 255)), 1'b0);
            end else begin
              send_octet(8'(addr_len), 1'b0);
              send_octet((fault == FAULT_TOA) ? ADDRESS_TYPE ^ 8'($urandom_range(1, 255)) :
                         ADDRESS_TYPE, 1'b0);
              while (frame_board.phase == PH_ADDR) send_octet(8'($urandom()), 1'b0);
            end
          end else begin
            // Noise: stray bytes, then a random start byte
            repeat ($urandom_range(1, 4)) send_octet(8'($urandom()), 1'b0);
            send_octet(8'($urandom()), 1'b1);
          end
        end
      endcase
      frame_no++;
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    while (frame_board.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (frame_board.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule : sms_inbound_pdu_parser_tb

/* sms_inbound_pdu_parser.f */
src/sip_pkg.sv
src/sms_inbound_pdu_parser.sv
dv/sms_inbound_pdu_parser_tb.sv
